// ===== design/tfj_pkg.sv =====
`default_nettype none
package tfj_pkg;
  localparam int MAX_LINE = 64;
  localparam int ADDR_W = $clog2(MAX_LINE);
  localparam int LEN_W = ADDR_W + 1;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_WORD_END = 2'd1;
  localparam logic [1:0] OP_TEXT_END = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [6:0] WIDTH_RESET = 7'd16;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_last;
  } out_t;
endpackage
`default_nettype wire

// ===== design/text_full_justifier.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_ready    | in_data (operation, char_byte)
// out     | output    | out_valid / out_ready  | out_data (out_char, line_last)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (max_width)
// A character or an unused code is taken in the idle state; an end of word writes the
// separator when the line already holds a word, then copies each character from the
// word memory into the line memory.
// A line is emitted by walking its stored entries and padding spaces, after the gap
// divider if justified; output stalls hold the walk. Input is taken only when idle.
// Reset is synchronous; both memories need no clearing and width returns to 16.
`default_nettype none
module text_full_justifier (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tfj_pkg::in_t    in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tfj_pkg::out_t        out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [6:0]      cfg_data
);
  localparam int LW = tfj_pkg::LEN_W;
  localparam int AW = tfj_pkg::ADDR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_DAT  = 3'd3;
  localparam logic [2:0] S_SP   = 3'd4;
  localparam logic [2:0] S_SEP  = 3'd5;
  localparam logic [2:0] S_CR   = 3'd6;
  localparam logic [2:0] S_CW   = 3'd7;

  logic [2:0] state;
  logic [6:0] max_width;
  logic [LW-1:0] word_length, line_length, line_word_count;
  logic [LW-1:0] wl, base, j, pos, i, g, k;
  logic just, cont;

  logic [LW-1:0] w, wl_now, gaps, total;
  logic can_put, accept, fits_over, out_load;
  logic [LW:0] line_sum, cp_addr;

  logic word_we, line_we;
  logic [7:0] word_rdata;
  logic [8:0] line_wdata, line_rdata;
  logic [AW-1:0] line_waddr;
  logic div_start, div_busy;
  logic [LW-1:0] ave, extra;

  always_comb begin
    if (max_width == '0) begin
      w = LW'(1);
    end else if (max_width > 7'(tfj_pkg::MAX_LINE)) begin
      w = LW'(tfj_pkg::MAX_LINE);
    end else begin
      w = LW'(max_width);
    end
  end

  assign wl_now = (word_length < w) ? word_length : w;
  assign line_sum = {1'b0, line_length} + {1'b0, wl_now} + 1'b1;
  assign fits_over = (line_word_count != '0) && (line_sum > {1'b0, w});
  assign gaps = line_word_count - 1'b1;
  assign total = w - line_length + gaps;
  assign cp_addr = {1'b0, base} + {1'b0, j};

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign can_put = !out_valid || out_ready;

  assign word_we = accept && (in_data.operation == tfj_pkg::OP_CHAR) && (word_length < w);
  assign div_start = accept && (in_data.operation == tfj_pkg::OP_WORD_END) && fits_over
                     && (line_word_count >= LW'(2)) && (line_length < w);

  always_comb begin
    case (state)
      S_RD: out_load = (pos != w) && !(i < line_length) && can_put;
      S_DAT: out_load = !(just && line_rdata[8]) && can_put;
      S_SP: out_load = !(k == '0 || pos == w) && can_put;
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    line_we = 1'b0;
    line_waddr = cp_addr[AW-1:0];
    line_wdata = {1'b0, word_rdata};
    if (state == S_SEP) begin
      line_we = 1'b1;
      line_waddr = line_length[AW-1:0];
      line_wdata = {1'b1, tfj_pkg::SPACE_CHAR};
    end else if (state == S_CW) begin
      line_we = 1'b1;
    end
  end

  tfj_ram #(.DATA_W(8), .DEPTH(tfj_pkg::MAX_LINE)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_length[AW-1:0]),
    .wdata (in_data.char_byte),
    .raddr (j[AW-1:0]),
    .rdata (word_rdata)
  );

  tfj_ram #(.DATA_W(9), .DEPTH(tfj_pkg::MAX_LINE)) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (i[AW-1:0]),
    .rdata (line_rdata)
  );

  tfj_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (total),
    .divisor   (gaps),
    .busy      (div_busy),
    .quotient  (ave),
    .remainder (extra)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_width <= tfj_pkg::WIDTH_RESET;
      word_length <= '0;
      line_length <= '0;
      line_word_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        max_width <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pos <= '0;
            i <= '0;
            g <= '0;
            j <= '0;
            case (in_data.operation)
              tfj_pkg::OP_CHAR: begin
                if (word_we) begin
                  word_length <= word_length + 1'b1;
                end
              end
              tfj_pkg::OP_WORD_END: begin
                wl <= wl_now;
                if (fits_over) begin
                  cont <= 1'b1;
                  just <= div_start;
                  state <= div_start ? S_DIV : S_RD;
                end else if (line_word_count != '0) begin
                  base <= line_length + 1'b1;
                  state <= S_SEP;
                end else begin
                  base <= '0;
                  state <= S_CR;
                end
              end
              tfj_pkg::OP_TEXT_END: begin
                cont <= 1'b0;
                just <= 1'b0;
                word_length <= '0;
                state <= S_RD;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (pos == w) begin
            line_length <= '0;
            line_word_count <= '0;
            base <= '0;
            state <= cont ? S_CR : S_IDLE;
          end else if (i < line_length) begin
            state <= S_DAT;
          end else if (can_put) begin
            out_data.out_char <= tfj_pkg::SPACE_CHAR;
            out_data.line_last <= (pos + 1'b1 == w);
            pos <= pos + 1'b1;
          end
        end
        S_DAT: begin
          if (just && line_rdata[8]) begin
            k <= ave + LW'(g < extra);
            g <= g + 1'b1;
            state <= S_SP;
          end else if (can_put) begin
            out_data.out_char <= line_rdata[7:0];
            out_data.line_last <= (pos + 1'b1 == w);
            pos <= pos + 1'b1;
            i <= i + 1'b1;
            state <= S_RD;
          end
        end
        S_SP: begin
          if (k == '0 || pos == w) begin
            i <= i + 1'b1;
            state <= S_RD;
          end else if (can_put) begin
            out_data.out_char <= tfj_pkg::SPACE_CHAR;
            out_data.line_last <= (pos + 1'b1 == w);
            pos <= pos + 1'b1;
            k <= k - 1'b1;
          end
        end
        S_SEP: begin
          state <= S_CR;
        end
        S_CR: begin
          if (j == wl || cp_addr >= (LW+1)'(tfj_pkg::MAX_LINE)) begin
            line_length <= base + wl;
            if (line_word_count != {LW{1'b1}}) begin
              line_word_count <= line_word_count + 1'b1;
            end
            word_length <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_CW;
          end
        end
        S_CW: begin
          j <= j + 1'b1;
          state <= S_CR;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/tfj_ram.sv =====
`default_nettype none
module tfj_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/tfj_div.sv =====
`default_nettype none
module tfj_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [tfj_pkg::LEN_W-1:0] dividend,
  input  wire logic [tfj_pkg::LEN_W-1:0] divisor,
  output logic                           busy,
  output logic      [tfj_pkg::LEN_W-1:0] quotient,
  output logic      [tfj_pkg::LEN_W-1:0] remainder
);
  localparam int CNT_W = $clog2(tfj_pkg::LEN_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [tfj_pkg::LEN_W:0] shifted;
  logic [tfj_pkg::LEN_W:0] trial;

  assign shifted = {remainder, quotient[tfj_pkg::LEN_W-1]};
  assign trial = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(tfj_pkg::LEN_W);
      remainder <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[tfj_pkg::LEN_W]) begin
        remainder <= trial[tfj_pkg::LEN_W-1:0];
        quotient <= {quotient[tfj_pkg::LEN_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[tfj_pkg::LEN_W-1:0];
        quotient <= {quotient[tfj_pkg::LEN_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
